// ===== design/tss_pkg.sv =====
// Shared types, codes and a helper function for the touch slot tracker.
package tss_pkg;

    localparam int unsigned CoordW  = 12;
    localparam int unsigned CountW  = 4;
    localparam int unsigned NumSlots = 2;
    localparam int unsigned DiffW   = CoordW + 2;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_NEW      = 2'd1,
        ST_CONT     = 2'd2
    } slot_status_t;

    typedef enum logic [2:0] {
        SWIPE_NONE  = 3'd0,
        SWIPE_LEFT  = 3'd1,
        SWIPE_RIGHT = 3'd2,
        SWIPE_UP    = 3'd3,
        SWIPE_DOWN  = 3'd4
    } swipe_t;

    typedef enum logic {
        CFG_ENABLE    = 1'b0,
        CFG_THRESHOLD = 1'b1
    } cfg_index_t;

    localparam logic [CoordW-1:0] ThresholdReset = CoordW'(100);

    typedef struct packed {
        logic [CountW-1:0] contact_count;
        logic              first_slot;
        logic [CoordW-1:0] first_x;
        logic [CoordW-1:0] first_y;
        logic              second_slot;
        logic [CoordW-1:0] second_x;
        logic [CoordW-1:0] second_y;
    } scan_word_t;

    typedef struct packed {
        logic              touching;
        logic [CoordW-1:0] primary_x;
        logic [CoordW-1:0] primary_y;
        logic [2:0]        swipe;
        logic [1:0]        slot0_status;
        logic [1:0]        slot1_status;
        logic [CoordW-1:0] slot1_x;
        logic [CoordW-1:0] slot1_y;
    } result_word_t;

    typedef struct packed {
        slot_status_t [NumSlots-1:0]             status;
        logic [NumSlots-1:0][CoordW-1:0]         x;
        logic [NumSlots-1:0][CoordW-1:0]         y;
        logic [CoordW-1:0]                       start_x;
        logic [CoordW-1:0]                       start_y;
        logic                                    pressing;
    } track_state_t;

    function automatic slot_status_t advance_status(input slot_status_t s);
        advance_status = (s == ST_RELEASED) ? ST_NEW : ST_CONT;
    endfunction

endpackage

// ===== design/touch_slot_tracker_swipe_detect.sv =====
// Top level of the touch slot tracker: word registers, state and configuration.
// Each scan word is captured in an input register, processed by the slot and
// swipe logic while held there, and its result word is registered in an output
// register when the word advances. One word is accepted every cycle as
// long as the result side keeps taking words; the slot state is updated once
// per processed word, so consecutive scans run back to back. While enable is
// clear, accepted scans are consumed without changing state or producing a
// result. Configuration is written through cfg_we, cfg_index and cfg_data
// (index 0 enable, index 1 swipe threshold) and should only change while no
// scan is in flight.
module touch_slot_tracker_swipe_detect (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [tss_pkg::CoordW-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  tss_pkg::scan_word_t            in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tss_pkg::result_word_t          out_data
);

    logic                          enable_reg;
    logic [tss_pkg::CoordW-1:0]    threshold_reg;
    logic                          in_valid_reg;
    tss_pkg::scan_word_t           in_word_reg;
    logic                          out_valid_reg;
    tss_pkg::result_word_t         out_word_reg;
    tss_pkg::track_state_t         state_reg;
    tss_pkg::track_state_t         state_next;
    tss_pkg::result_word_t         result_next;
    logic                          advance;

    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    tss_scan_logic u_scan (
        .cur       (state_reg),
        .scan      (in_word_reg),
        .threshold (threshold_reg),
        .nxt       (state_next),
        .result    (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            threshold_reg <= tss_pkg::ThresholdReset;
        end
        else if (cfg_we)
        begin
            unique case (tss_pkg::cfg_index_t'(cfg_index))
                tss_pkg::CFG_ENABLE:    enable_reg    <= cfg_data[0];
                tss_pkg::CFG_THRESHOLD: threshold_reg <= cfg_data;
                default:                enable_reg    <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_word_reg <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= enable_reg;
            if (enable_reg)
            begin
                state_reg <= state_next;
            end
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && enable_reg)
        begin
            out_word_reg <= result_next;
        end
    end

    // A held scan word must not be dropped while the result side stalls.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg)
        else $error("scan word lost while stalled");

    // Disabled scans never produce a result word.
    a_no_result_disabled: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !enable_reg |=> !out_valid_reg)
        else $error("result produced while disabled");

    a_release_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_word_reg.touching |->
            out_word_reg.slot0_status == tss_pkg::ST_RELEASED &&
            out_word_reg.slot1_status == tss_pkg::ST_RELEASED &&
            out_word_reg.swipe == tss_pkg::SWIPE_NONE)
        else $error("slots not released without contacts");

    // Slot 1 never holds a lone contact after the move into slot 0.
    a_single_contact_slot1: assert property (@(posedge clk) disable iff (!rst_n)
        advance && enable_reg && in_word_reg.contact_count == tss_pkg::CountW'(1)
            |=> out_word_reg.slot1_status == tss_pkg::ST_RELEASED)
        else $error("slot 1 not released for a single contact");

endmodule

// ===== design/tss_scan_logic.sv =====
// Combinational update of the slot state and result word for one scan.
module tss_scan_logic (
    input  tss_pkg::track_state_t                cur,
    input  tss_pkg::scan_word_t                  scan,
    input  logic [tss_pkg::CoordW-1:0]           threshold,
    output tss_pkg::track_state_t                nxt,
    output tss_pkg::result_word_t                result
);

    tss_pkg::track_state_t                 wr_a;
    tss_pkg::track_state_t                 wr_b;
    logic [tss_pkg::CoordW-1:0]            px;
    logic [tss_pkg::CoordW-1:0]            py;
    logic [tss_pkg::CoordW-1:0]            sx;
    logic [tss_pkg::CoordW-1:0]            sy;
    logic signed [tss_pkg::DiffW-1:0]      dx;
    logic signed [tss_pkg::DiffW-1:0]      dy;
    logic signed [tss_pkg::DiffW-1:0]      thr_pos;
    logic signed [tss_pkg::DiffW-1:0]      thr_neg;
    tss_pkg::swipe_t                       swipe;
    logic                                  touch;

    // Two contacts are applied in order, so a shared slot advances twice.
    always_comb
    begin
        wr_a = cur;
        wr_a.status[scan.first_slot] = tss_pkg::advance_status(cur.status[scan.first_slot]);
        wr_a.x[scan.first_slot] = scan.first_x;
        wr_a.y[scan.first_slot] = scan.first_y;
        wr_b = wr_a;
        wr_b.status[scan.second_slot] =
            tss_pkg::advance_status(wr_a.status[scan.second_slot]);
        wr_b.x[scan.second_slot] = scan.second_x;
        wr_b.y[scan.second_slot] = scan.second_y;
    end

    always_comb
    begin
        nxt = cur;
        touch = (scan.contact_count != '0);
        if (!touch)
        begin
            nxt.status[0] = tss_pkg::ST_RELEASED;
            nxt.status[1] = tss_pkg::ST_RELEASED;
        end
        else if (scan.contact_count == tss_pkg::CountW'(1))
        begin
            if (!scan.first_slot)
            begin
                nxt = wr_a;
                nxt.status[1] = tss_pkg::ST_RELEASED;
            end
            else
            begin
                // A lone contact in slot 1 is moved into slot 0.
                nxt = wr_a;
                nxt.status[0] = wr_a.status[1];
                nxt.x[0] = wr_a.x[1];
                nxt.y[0] = wr_a.y[1];
                nxt.status[1] = tss_pkg::ST_RELEASED;
            end
        end
        else
        begin
            nxt = wr_b;
        end

        px = nxt.x[0];
        py = nxt.y[0];
        sx = cur.pressing ? cur.start_x : px;
        sy = cur.pressing ? cur.start_y : py;
        nxt.pressing = touch;
        if (touch)
        begin
            nxt.start_x = sx;
            nxt.start_y = sy;
        end

        dx = $signed({2'b00, sx}) - $signed({2'b00, px});
        dy = $signed({2'b00, sy}) - $signed({2'b00, py});
        thr_pos = $signed({2'b00, threshold});
        thr_neg = -thr_pos;

        priority if (!touch)
            swipe = tss_pkg::SWIPE_NONE;
        else if (dx > thr_pos)
            swipe = tss_pkg::SWIPE_LEFT;
        else if (dx < thr_neg)
            swipe = tss_pkg::SWIPE_RIGHT;
        else if (dy > thr_pos)
            swipe = tss_pkg::SWIPE_UP;
        else if (dy < thr_neg)
            swipe = tss_pkg::SWIPE_DOWN;
        else
            swipe = tss_pkg::SWIPE_NONE;

        result.touching     = touch;
        result.primary_x    = touch ? px : '0;
        result.primary_y    = touch ? py : '0;
        result.swipe        = swipe;
        result.slot0_status = nxt.status[0];
        result.slot1_status = nxt.status[1];
        result.slot1_x      = nxt.x[1];
        result.slot1_y      = nxt.y[1];
    end

endmodule
